>>> rtl/core/ipv4dq_pkg.sv
`timescale 1ns / 1ps

package ipv4dq_pkg;

	// parser phase, also reported as the status field of each result beat
	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_BUSY  = 2'd1,
		PH_DONE  = 2'd2,
		PH_ERROR = 2'd3
	} phase_t;

	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_DOT  = 8'h2E;

	localparam int unsigned MAX_DIGITS = 3;
	localparam int unsigned LAST_OCTET = 3;

	localparam int unsigned CH_W     = 8;
	localparam int unsigned ADDR_W   = 32;
	localparam int unsigned LEN_W    = 4;
	localparam int unsigned OUT_W    = 40;

endpackage

>>> rtl/core/ipv4_dotted_quad_parser_top.sv
`timescale 1ns / 1ps

// IPv4 dotted-decimal parser. Feed the address text one ASCII character per
// beat on s_axis; set s_axis_tuser on the first character of a new address to
// restart the parser. Every input beat yields exactly one result beat on
// m_axis carrying the status (idle, parsing, complete, error), the address
// (first octet in bits 31..24, nonzero only when complete), the number of
// characters consumed so far, and whether this character was part of the
// address. Octets are one to three digits and wrap modulo 256; the first three
// must be followed by a dot, and the last one ends after three digits or at a
// non-digit, which is reported as not used. Throughput is one character per
// clock while neither side stalls; the path runs through an input register
// and a result register, with the whole per-character state update (one
// multiply-by-ten add and a few compares) done combinationally between them.
// Either side may stall freely; a full result register does not stop the
// input register from holding the next character.
module ipv4_dotted_quad_parser_top (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] ch
	input  logic        s_axis_tuser,   // [0] start_req

	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata    // [1:0] status, [33:2] address,
	                                    // [37:34] length, [38] char_used, [39] zero
);

	localparam logic [ipv4dq_pkg::LEN_W-1:0] LEN_ONE = 1;

	// input register
	logic                            valid_s1;
	logic [ipv4dq_pkg::CH_W-1:0]     ch_s1;
	logic                            start_s1;

	// result register
	logic                            valid_s2;
	ipv4dq_pkg::phase_t              status_s2;
	logic [ipv4dq_pkg::ADDR_W-1:0]   addr_s2;
	logic [ipv4dq_pkg::LEN_W-1:0]    len_s2;
	logic                            used_s2;

	// parser state
	ipv4dq_pkg::phase_t              phase_q;
	logic [1:0]                      oct_idx_q;
	logic [1:0]                      dig_cnt_q;
	logic [7:0]                      oct_val_q;
	logic [23:0]                     part_addr_q;
	logic [ipv4dq_pkg::LEN_W-1:0]    chr_cnt_q;

	// next state from the combinational step
	ipv4dq_pkg::phase_t              phase_d;
	logic [1:0]                      oct_idx_d;
	logic [1:0]                      dig_cnt_d;
	logic [7:0]                      oct_val_d;
	logic [23:0]                     part_addr_d;
	logic [ipv4dq_pkg::LEN_W-1:0]    chr_cnt_d;
	logic                            used_d;
	logic [ipv4dq_pkg::ADDR_W-1:0]   addr_d;

	logic adv;     // s1 moves into the result register
	logic take_in;

	assign adv           = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;
	assign take_in       = s_axis_tvalid && s_axis_tready;

	// one character step
	always_comb begin
		logic       is_dig;
		logic [3:0] dval;
		logic [7:0] mul10;

		is_dig = (ch_s1 >= ipv4dq_pkg::CH_ZERO) && (ch_s1 <= ipv4dq_pkg::CH_NINE);
		dval   = ch_s1[3:0];  // low nibble of an ASCII digit is its value
		mul10  = {oct_val_q[4:0], 3'b000} + {oct_val_q[6:0], 1'b0};

		// a start restarts from a cleared parse
		if (start_s1) begin
			phase_d     = ipv4dq_pkg::PH_BUSY;
			oct_idx_d   = 2'd0;
			dig_cnt_d   = 2'd0;
			oct_val_d   = 8'd0;
			part_addr_d = 24'd0;
			chr_cnt_d   = '0;
		end else begin
			phase_d     = phase_q;
			oct_idx_d   = oct_idx_q;
			dig_cnt_d   = dig_cnt_q;
			oct_val_d   = oct_val_q;
			part_addr_d = part_addr_q;
			chr_cnt_d   = chr_cnt_q;
		end
		used_d = 1'b0;

		if (phase_d == ipv4dq_pkg::PH_BUSY) begin
			if (dig_cnt_d == 2'd0) begin
				if (!is_dig) begin
					phase_d = ipv4dq_pkg::PH_ERROR;
				end else begin
					oct_val_d = {4'd0, dval};
					dig_cnt_d = 2'd1;
					chr_cnt_d = chr_cnt_d + LEN_ONE;
					used_d    = 1'b1;
				end
			end else if (dig_cnt_d < 2'(ipv4dq_pkg::MAX_DIGITS) && is_dig) begin
				// dig_cnt_d nonzero here, so the state is unchanged by start
				oct_val_d = mul10 + {4'd0, dval};
				dig_cnt_d = dig_cnt_d + 2'd1;
				chr_cnt_d = chr_cnt_d + LEN_ONE;
				used_d    = 1'b1;
				if (oct_idx_d == 2'(ipv4dq_pkg::LAST_OCTET) &&
				    dig_cnt_d == 2'(ipv4dq_pkg::MAX_DIGITS)) begin
					phase_d = ipv4dq_pkg::PH_DONE;
				end
			end else if (oct_idx_d == 2'(ipv4dq_pkg::LAST_OCTET)) begin
				// non-digit closes the last octet, not consumed
				phase_d = ipv4dq_pkg::PH_DONE;
			end else if (ch_s1 == ipv4dq_pkg::CH_DOT) begin
				part_addr_d = {part_addr_d[15:0], oct_val_d};
				oct_idx_d   = oct_idx_d + 2'd1;
				dig_cnt_d   = 2'd0;
				oct_val_d   = 8'd0;
				chr_cnt_d   = chr_cnt_d + LEN_ONE;
				used_d      = 1'b1;
			end else begin
				phase_d = ipv4dq_pkg::PH_ERROR;
			end
		end

		addr_d = (phase_d == ipv4dq_pkg::PH_DONE) ? {part_addr_d, oct_val_d} : '0;
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			ch_s1    <= s_axis_tdata;
			start_s1 <= s_axis_tuser;
		end
	end

	// parser state advances once per character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= ipv4dq_pkg::PH_IDLE;
			oct_idx_q   <= 2'd0;
			dig_cnt_q   <= 2'd0;
			oct_val_q   <= 8'd0;
			part_addr_q <= 24'd0;
			chr_cnt_q   <= '0;
		end else if (adv) begin
			phase_q     <= phase_d;
			oct_idx_q   <= oct_idx_d;
			dig_cnt_q   <= dig_cnt_d;
			oct_val_q   <= oct_val_d;
			part_addr_q <= part_addr_d;
			chr_cnt_q   <= chr_cnt_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_s2 <= phase_d;
			addr_s2   <= addr_d;
			len_s2    <= chr_cnt_d;
			used_s2   <= used_d;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {1'b0, used_s2, len_s2, addr_s2, status_s2};

endmodule
